[design/pnmbsp_pkg.sv]
// ----------------------------------------------------------------------------
// pnmbsp_pkg
// Shared types and constants of the binary PGM/PPM stream parser.
// ----------------------------------------------------------------------------
package pnmbsp_pkg;

  localparam int DIM_BITS_DEF  = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int VALUE_W       = 16;
  localparam int PIXEL_W       = 17;

  localparam logic [VALUE_W-1:0] ERR_BAD_MAGIC   = 16'd0;
  localparam logic [VALUE_W-1:0] ERR_UNSUPPORTED = 16'd1;
  localparam logic [VALUE_W-1:0] ERR_BAD_NUMBER  = 16'd2;
  localparam logic [VALUE_W-1:0] ERR_BAD_MAXVAL  = 16'd3;

  typedef enum logic [2:0] {
    KIND_WIDTH  = 3'd0,
    KIND_HEIGHT = 3'd1,
    KIND_MAXVAL = 3'd2,
    KIND_PIXEL  = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_e;

  typedef struct packed {
    logic               emit;
    logic               pix;
    kind_e              kind;
    logic [VALUE_W-1:0] value;
    logic [7:0]         maxval;
    logic [1:0]         channel;
    logic               last;
  } parse_res_t;

endpackage

[design/pnmbsp_div.sv]
// ----------------------------------------------------------------------------
// pnmbsp_div
// Bit-serial restoring divider: component * 2^FRAC_BITS / maxval, rounded.
// ----------------------------------------------------------------------------
module pnmbsp_div #(
  parameter int FRAC_BITS = pnmbsp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [7:0]                      byte_i,
  input  logic [7:0]                      maxval_i,
  input  logic                            take_i,
  output logic                            busy_o,
  output logic                            done_o,
  output logic [pnmbsp_pkg::PIXEL_W-1:0]  pixel_o
);

  localparam int NumW = 8 + FRAC_BITS;
  localparam int CntW = $clog2(NumW + 1);
  localparam int PixW = pnmbsp_pkg::PIXEL_W;
  localparam logic [NumW-1:0] One = {{(NumW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [CntW-1:0] CntInit = CntW'(NumW);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num_q, num_d;
  logic [7:0]      rem_q, rem_d;
  logic [7:0]      den_q, den_d;
  logic [8:0]      rem_sh;
  logic [8:0]      diff;
  logic            ge;
  logic [NumW-1:0] sat;

  assign rem_sh = {rem_q, num_q[NumW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        cnt_d  = CntInit;
        num_d  = {byte_i, {FRAC_BITS{1'b0}}} + NumW'(maxval_i >> 1);
        rem_d  = '0;
        den_d  = maxval_i;
      end
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CntW'(1);
      num_d = {num_q[NumW-2:0], ge};
      rem_d = ge ? diff[7:0] : rem_sh[7:0];
    end else if (take_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sat     = (num_q > One) ? One : num_q;
  assign busy_o  = busy_q;
  assign done_o  = busy_q && (cnt_q == '0);
  assign pixel_o = PixW'(sat[FRAC_BITS:0]);

endmodule

[design/pnmbsp_parse.sv]
// ----------------------------------------------------------------------------
// pnmbsp_parse
// Header state machine: magic, decimal header numbers and pixel counting.
// ----------------------------------------------------------------------------
module pnmbsp_parse #(
  parameter int DIM_BITS = pnmbsp_pkg::DIM_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             byte_i,
  input  logic                   first_i,
  input  logic                   fire_i,
  output pnmbsp_pkg::parse_res_t res_o
);

  typedef enum logic [6:0] {
    PH_MAGIC0 = 7'b0000001,
    PH_MAGIC1 = 7'b0000010,
    PH_WIDTH  = 7'b0000100,
    PH_HEIGHT = 7'b0001000,
    PH_MAXVAL = 7'b0010000,
    PH_PIXELS = 7'b0100000,
    PH_IDLE   = 7'b1000000
  } phase_e;

  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch1     = 8'h31;
  localparam logic [7:0] Ch4     = 8'h34;
  localparam logic [7:0] Ch5     = 8'h35;
  localparam logic [7:0] Ch6     = 8'h36;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] MaxVal  = 8'd255;

  localparam logic [15:0] DimMax = 16'((32'd1 << DIM_BITS) - 32'd1);

  phase_e              phase_q, phase_d, ph;
  logic [15:0]         acc_q, acc_d, acc_cur;
  logic                seen_q, seen_d, seen_cur;
  logic                color_q, color_d;
  logic [DIM_BITS-1:0] width_q, width_d;
  logic [DIM_BITS-1:0] height_q, height_d;
  logic [7:0]          max_q, max_d;
  logic [DIM_BITS-1:0] col_q, col_d;
  logic [DIM_BITS-1:0] row_q, row_d;
  logic [1:0]          ch_q, ch_d;

  logic                is_digit, is_ws;
  logic [19:0]         acc_sum;
  logic [DIM_BITS-1:0] dim_sat;

  assign ph       = first_i ? PH_MAGIC0 : phase_q;
  assign acc_cur  = first_i ? 16'd0 : acc_q;
  assign seen_cur = first_i ? 1'b0 : seen_q;
  assign is_digit = (byte_i >= Ch0) && (byte_i <= Ch9);
  assign is_ws    = (byte_i == ChSpace) || (byte_i == ChTab) ||
                    (byte_i == ChLf) || (byte_i == ChCr);
  assign acc_sum  = 20'({acc_cur, 3'b000}) + 20'({acc_cur, 1'b0}) + 20'(byte_i - Ch0);
  assign dim_sat  = (acc_cur > DimMax) ? DIM_BITS'(DimMax) : DIM_BITS'(acc_cur);

  always_comb begin
    phase_d  = ph;
    acc_d    = acc_cur;
    seen_d   = seen_cur;
    color_d  = color_q;
    width_d  = width_q;
    height_d = height_q;
    max_d    = max_q;
    col_d    = col_q;
    row_d    = row_q;
    ch_d     = ch_q;
    res_o         = '0;
    res_o.kind    = pnmbsp_pkg::KIND_ERROR;
    res_o.maxval  = max_q;

    unique case (ph)
      PH_MAGIC0: begin
        if (byte_i != ChP) begin
          res_o.emit  = 1'b1;
          res_o.value = pnmbsp_pkg::ERR_BAD_MAGIC;
          phase_d     = PH_IDLE;
        end else begin
          phase_d = PH_MAGIC1;
        end
      end
      PH_MAGIC1: begin
        if (byte_i >= Ch1 && byte_i <= Ch4) begin
          res_o.emit  = 1'b1;
          res_o.value = pnmbsp_pkg::ERR_UNSUPPORTED;
          phase_d     = PH_IDLE;
        end else if (byte_i != Ch5 && byte_i != Ch6) begin
          res_o.emit  = 1'b1;
          res_o.value = pnmbsp_pkg::ERR_BAD_MAGIC;
          phase_d     = PH_IDLE;
        end else begin
          color_d = (byte_i == Ch6);
          acc_d   = '0;
          seen_d  = 1'b0;
          phase_d = PH_WIDTH;
        end
      end
      PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
        if (is_digit) begin
          acc_d  = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];
          seen_d = 1'b1;
        end else if (!is_ws) begin
          res_o.emit  = 1'b1;
          res_o.value = pnmbsp_pkg::ERR_BAD_NUMBER;
          phase_d     = PH_IDLE;
        end else if (seen_cur) begin
          acc_d      = '0;
          seen_d     = 1'b0;
          res_o.emit = 1'b1;
          if (ph == PH_WIDTH) begin
            width_d     = dim_sat;
            res_o.kind  = pnmbsp_pkg::KIND_WIDTH;
            res_o.value = 16'(dim_sat);
            phase_d     = PH_HEIGHT;
          end else if (ph == PH_HEIGHT) begin
            height_d    = dim_sat;
            res_o.kind  = pnmbsp_pkg::KIND_HEIGHT;
            res_o.value = 16'(dim_sat);
            phase_d     = PH_MAXVAL;
          end else if (acc_cur == 16'd0 || acc_cur > 16'(MaxVal)) begin
            res_o.value = pnmbsp_pkg::ERR_BAD_MAXVAL;
            phase_d     = PH_IDLE;
          end else begin
            max_d       = acc_cur[7:0];
            col_d       = '0;
            row_d       = '0;
            ch_d        = '0;
            res_o.kind  = pnmbsp_pkg::KIND_MAXVAL;
            res_o.value = acc_cur;
            phase_d     = (width_q == '0 || height_q == '0) ? PH_IDLE : PH_PIXELS;
          end
        end
      end
      PH_PIXELS: begin
        res_o.emit    = 1'b1;
        res_o.pix     = 1'b1;
        res_o.kind    = pnmbsp_pkg::KIND_PIXEL;
        res_o.channel = color_q ? ch_q : 2'd0;
        if (ch_q >= (color_q ? 2'd2 : 2'd0)) begin
          ch_d = '0;
          if (col_q == width_q - DIM_BITS'(1)) begin
            col_d = '0;
            if (row_q == height_q - DIM_BITS'(1)) begin
              res_o.last = 1'b1;
              phase_d    = PH_IDLE;
            end else begin
              row_d = row_q + DIM_BITS'(1);
            end
          end else begin
            col_d = col_q + DIM_BITS'(1);
          end
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_MAGIC0;
      acc_q    <= '0;
      seen_q   <= 1'b0;
      color_q  <= 1'b0;
      width_q  <= '0;
      height_q <= '0;
      max_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      ch_q     <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      seen_q   <= seen_d;
      color_q  <= color_d;
      width_q  <= width_d;
      height_q <= height_d;
      max_q    <= max_d;
      col_q    <= col_d;
      row_q    <= row_d;
      ch_q     <= ch_d;
    end
  end

endmodule

[design/pnm_binary_stream_parser_unit.sv]
// ----------------------------------------------------------------------------
// pnm_binary_stream_parser_unit
// Binary PGM (P5) / PPM (P6) byte stream parser with pixel normalization.
// ----------------------------------------------------------------------------
// Input channel: one file byte per transaction (byte_req_i, first_i), with
// first_i high on the first byte of each file. Output channel: one result
// transaction (kind_o, value_o, pixel_o, channel_o, last_o) for each byte
// that ends a header number, carries a pixel component or raises an error.
// Header bytes pass through a one-entry input register and the parser; a
// header result is registered in the output register when its byte fires.
// A pixel component runs through a bit-serial divider, one quotient bit a
// cycle, and the parser takes no new byte until the divider has handed its
// result to the output register, so that divider sets the pixel rate. The
// input register takes the next byte while a result waits in the output
// register. When the receiver stalls, the output register holds, the
// divider holds its quotient and the input register fills, then in_ready_o
// drops. Reset empties the input and output registers, idles the divider
// and returns the parser to waiting for the magic.
// ----------------------------------------------------------------------------
module pnm_binary_stream_parser_unit #(
  parameter int DIM_BITS  = pnmbsp_pkg::DIM_BITS_DEF,
  parameter int FRAC_BITS = pnmbsp_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [7:0]                       byte_req_i,
  input  logic                             first_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [2:0]                       kind_o,
  output logic [pnmbsp_pkg::VALUE_W-1:0]   value_o,
  output logic [pnmbsp_pkg::PIXEL_W-1:0]   pixel_o,
  output logic [1:0]                       channel_o,
  output logic                             last_o
);

  logic                   in_valid_q;
  logic [7:0]             byte_q;
  logic                   first_q;
  pnmbsp_pkg::parse_res_t res;
  logic                   fire, out_free, hdr_load, div_start, div_take;
  logic                   div_busy, div_done;
  logic [pnmbsp_pkg::PIXEL_W-1:0] div_pixel;
  logic [1:0]             tag_ch_q;
  logic                   tag_last_q;

  logic                   out_valid_q;
  pnmbsp_pkg::kind_e      kind_q;
  logic [pnmbsp_pkg::VALUE_W-1:0] value_q;
  logic [pnmbsp_pkg::PIXEL_W-1:0] pixel_q;
  logic [1:0]             channel_q;
  logic                   last_q;

  pnmbsp_parse #(
    .DIM_BITS(DIM_BITS)
  ) u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_q),
    .first_i (first_q),
    .fire_i  (fire),
    .res_o   (res)
  );

  pnmbsp_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .byte_i   (byte_q),
    .maxval_i (res.maxval),
    .take_i   (div_take),
    .busy_o   (div_busy),
    .done_o   (div_done),
    .pixel_o  (div_pixel)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && !div_busy && (!res.emit || res.pix || out_free);
  assign hdr_load   = fire && res.emit && !res.pix;
  assign div_start  = fire && res.pix;
  assign div_take   = div_done && out_free;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (hdr_load || div_take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q  <= byte_req_i;
      first_q <= first_i;
    end
    if (div_start) begin
      tag_ch_q   <= res.channel;
      tag_last_q <= res.last;
    end
    if (hdr_load) begin
      kind_q    <= res.kind;
      value_q   <= res.value;
      pixel_q   <= '0;
      channel_q <= '0;
      last_q    <= 1'b0;
    end else if (div_take) begin
      kind_q    <= pnmbsp_pkg::KIND_PIXEL;
      value_q   <= '0;
      pixel_q   <= div_pixel;
      channel_q <= tag_ch_q;
      last_q    <= tag_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign pixel_o     = pixel_q;
  assign channel_o   = channel_q;
  assign last_o      = last_q;

endmodule
